// ===== sv/gcd_pkg.sv =====
// Shared constants, types and the arctangent table for the great-circle distance pipeline.
package gcd_pkg;

  localparam int CORDIC_STAGES_DEF = 24;

  // angle in 5e-8 degree units, signed; reduced angle fits in 33 bits unsigned
  localparam int UW = 34;
  localparam int RW = 33;
  // CORDIC datapath widths: x/y Q30 with headroom, z radians Q30 signed
  localparam int XW = 34;
  localparam int ZW = 33;
  localparam int DW = 25;

  localparam logic [RW-1:0] TURN_UNITS    = 33'd7200000000;
  localparam logic [RW-1:0] QUARTER_UNITS = 33'd1800000000;
  localparam logic [RW-1:0] HALF_UNITS    = 33'd3600000000;
  localparam logic [RW-1:0] THREE_Q_UNITS = 33'd5400000000;
  localparam logic [31:0]   RAD_SCALE     = 32'd4024455254;
  localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sh026DD3B6A;
  localparam logic [23:0]   TWO_R_METERS  = 24'd12742000;

  localparam logic [31:0] ATAN_HEAD [10] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD
  };

  typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;

  typedef struct packed {
    logic  valid;
    quad_t quad;
  } rot_tag_t;

  // floor(atan(2^-i) * 2^30); zero past the fraction bits
  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] v;
    v = '0;
    if (i < 10) begin
      v = {1'b0, ATAN_HEAD[i]};
    end else if (i < 30) begin
      v = ZW'((33'sd1 <<< (30 - i)) - 33'sd1);
    end
    return v;
  endfunction

endpackage

// ===== sv/great_circle_distance_top.sv =====
// Top level: haversine great-circle distance pipeline from two lat/lon pairs to meters.
// A request (start high while busy is low) is taken every cycle; busy stays low, since
// the pipeline never stalls. The distance appears on distance_m with done high for one
// cycle. Its path runs through the two CORDIC chains, one stage each per iteration, and
// the 31-stage square root. The receiver cannot hold results off, so each must be
// captured in its done cycle.
module great_circle_distance_top
  import gcd_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [30:0]   lat_a,
  input  logic signed [31:0]   lon_a,
  input  logic signed [30:0]   lat_b,
  input  logic signed [31:0]   lon_b,
  output logic                 done,
  output logic [DW-1:0]        distance_m
);

  localparam int LAT = 2 * CORDIC_STAGES + 44;
  localparam int PW  = 2 * XW;

  logic                 v0;
  logic signed [UW-1:0] u_dlat, u_dlon, u_la, u_lb;
  rot_tag_t             tg_dlat, tg_dlon, tg_la, tg_lb;
  logic signed [ZW-1:0] z_dlat, z_dlon, z_la, z_lb;
  logic                 rv_dlat, rv_dlon, rv_la, rv_lb;
  logic signed [XW-1:0] sa, so, c1, c2;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    u_dlat <= UW'(lat_b) - UW'(lat_a);
    u_dlon <= UW'(lon_b) - UW'(lon_a);
    u_la   <= UW'(lat_a) <<< 1;
    u_lb   <= UW'(lat_b) <<< 1;
  end

  gcd_angle_prep u_prep_dlat (.clk, .rst, .in_valid(v0), .u(u_dlat), .tag(tg_dlat), .z(z_dlat));
  gcd_angle_prep u_prep_dlon (.clk, .rst, .in_valid(v0), .u(u_dlon), .tag(tg_dlon), .z(z_dlon));
  gcd_angle_prep u_prep_la   (.clk, .rst, .in_valid(v0), .u(u_la),   .tag(tg_la),   .z(z_la));
  gcd_angle_prep u_prep_lb   (.clk, .rst, .in_valid(v0), .u(u_lb),   .tag(tg_lb),   .z(z_lb));

  gcd_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot_dlat (
    .clk, .rst, .in_tag(tg_dlat), .in_z(z_dlat), .valid(rv_dlat), .sin_q(sa), .cos_q()
  );
  gcd_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot_dlon (
    .clk, .rst, .in_tag(tg_dlon), .in_z(z_dlon), .valid(rv_dlon), .sin_q(so), .cos_q()
  );
  gcd_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot_la (
    .clk, .rst, .in_tag(tg_la), .in_z(z_la), .valid(rv_la), .sin_q(), .cos_q(c1)
  );
  gcd_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot_lb (
    .clk, .rst, .in_tag(tg_lb), .in_z(z_lb), .valid(rv_lb), .sin_q(), .cos_q(c2)
  );

  // haversine term a = sa^2 + ((c1*c2 >> 30) * so >> 30) * so, clamped to [0, 1]
  logic                 h1, h2, h3, h4, h5;
  logic signed [PW-1:0] pc1, sa2_1, sa2_2, sa2_3, pso2, prod3;
  logic signed [XW-1:0] so1, so2, pq, tq;
  logic signed [PW:0]   asum;
  logic [60:0]          a4, ra_in, rb_in;

  assign pq   = XW'(pc1 >>> 30);
  assign tq   = XW'(pso2 >>> 30);
  assign asum = (PW+1)'(sa2_3) + (PW+1)'(prod3);

  always_ff @(posedge clk) begin
    if (rst) begin
      h1 <= 1'b0;
      h2 <= 1'b0;
      h3 <= 1'b0;
      h4 <= 1'b0;
      h5 <= 1'b0;
    end else begin
      h1 <= rv_dlat;
      h2 <= h1;
      h3 <= h2;
      h4 <= h3;
      h5 <= h4;
    end
  end

  always_ff @(posedge clk) begin
    pc1   <= PW'(c1) * PW'(c2);
    sa2_1 <= PW'(sa) * PW'(sa);
    so1   <= so;
    pso2  <= PW'(pq) * PW'(so1);
    sa2_2 <= sa2_1;
    so2   <= so1;
    prod3 <= PW'(tq) * PW'(so2);
    sa2_3 <= sa2_2;
    priority if (asum[PW]) begin
      a4 <= '0;
    end else if (asum > (PW+1)'(61'h1000000000000000)) begin
      a4 <= 61'h1000000000000000;
    end else begin
      a4 <= asum[60:0];
    end
    ra_in <= a4;
    rb_in <= 61'h1000000000000000 - a4;
  end

  logic        qv_a, qv_b;
  logic [30:0] ra, rb;

  gcd_isqrt u_sqrt_a (.clk, .rst, .in_valid(h5), .v(ra_in), .valid(qv_a), .root(ra));
  gcd_isqrt u_sqrt_b (.clk, .rst, .in_valid(h5), .v(rb_in), .valid(qv_b), .root(rb));

  logic                 av;
  logic signed [ZW-1:0] zang;

  gcd_cordic_vec #(.STAGES(CORDIC_STAGES)) u_atan (
    .clk, .rst, .in_valid(qv_a), .in_y(ra), .in_x(rb), .valid(av), .angle(zang)
  );

  logic        f1;
  logic [54:0] dprod, drnd;

  assign drnd = dprod + 55'h20000000;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1   <= 1'b0;
      done <= 1'b0;
    end else begin
      f1   <= av;
      done <= f1;
    end
  end

  // drop a negative residual angle to zero, then scale by the diameter and round
  always_ff @(posedge clk) begin
    dprod      <= zang[ZW-1] ? '0 : 55'(zang[30:0]) * 55'(TWO_R_METERS);
    distance_m <= drnd[30+DW-1:30];
  end

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    (rv_dlat == rv_dlon) && (rv_dlat == rv_la) && (rv_dlat == rv_lb))
    else $error("sine/cosine lanes out of step");

  a_sqrt_aligned: assert property (@(posedge clk) disable iff (rst) qv_a == qv_b)
    else $error("square root lanes out of step");

  a_done_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without a request");

  a_request_gives_done: assert property (@(posedge clk) disable iff (rst)
    start |-> ##LAT done)
    else $error("request produced no result");

endmodule

// ===== sv/gcd_angle_prep.sv =====
// Angle reduction to quadrant and radians, ahead of the rotation CORDIC.
module gcd_angle_prep
  import gcd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [UW-1:0] u,
  output rot_tag_t             tag,
  output logic signed [ZW-1:0] z
);

  logic signed [UW:0] wrapped;
  logic [RW-1:0]      r1;
  logic               v1;
  rot_tag_t           tag2, tag3;
  logic [30:0]        t2;
  logic [62:0]        prod3;
  logic [30:0]        z4;
  logic [62:0]        rounded;

  assign wrapped = (UW+1)'(u) + (UW+1)'(signed'({1'b0, TURN_UNITS}));
  assign rounded = prod3 + 63'h80000000;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      tag2 <= '0;
      tag3 <= '0;
      tag  <= '0;
    end else begin
      v1         <= in_valid;
      tag2.valid <= v1;
      priority if (r1 >= THREE_Q_UNITS) begin
        tag2.quad <= QUAD_3;
      end else if (r1 >= HALF_UNITS) begin
        tag2.quad <= QUAD_2;
      end else if (r1 >= QUARTER_UNITS) begin
        tag2.quad <= QUAD_1;
      end else begin
        tag2.quad <= QUAD_0;
      end
      tag3 <= tag2;
      tag  <= tag3;
    end
  end

  always_ff @(posedge clk) begin
    r1 <= u[UW-1] ? wrapped[RW-1:0] : u[RW-1:0];
    priority if (r1 >= THREE_Q_UNITS) begin
      t2 <= 31'(r1 - THREE_Q_UNITS);
    end else if (r1 >= HALF_UNITS) begin
      t2 <= 31'(r1 - HALF_UNITS);
    end else if (r1 >= QUARTER_UNITS) begin
      t2 <= 31'(r1 - QUARTER_UNITS);
    end else begin
      t2 <= r1[30:0];
    end
    prod3 <= 63'(t2) * 63'(RAD_SCALE);
    z4    <= rounded[62:32];
  end

  assign z = {2'b00, z4};

endmodule

// ===== sv/gcd_cordic_rot.sv =====
// Rotation-mode CORDIC pipeline, one stage per register, with quadrant fold-back.
module gcd_cordic_rot
  import gcd_pkg::*;
#(
  parameter int STAGES = CORDIC_STAGES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rot_tag_t             in_tag,
  input  logic signed [ZW-1:0] in_z,
  output logic                 valid,
  output logic signed [XW-1:0] sin_q,
  output logic signed [XW-1:0] cos_q
);

  logic signed [XW-1:0] xs [STAGES];
  logic signed [XW-1:0] ys [STAGES];
  logic signed [ZW-1:0] zs [STAGES];
  rot_tag_t             tg [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [ZW-1:0] ATAN_I = atan_q30(i);
    logic signed [XW-1:0] xin, yin;
    logic signed [ZW-1:0] zin;
    rot_tag_t             tin;
    if (i == 0) begin : g_first
      assign xin = CORDIC_GAIN;
      assign yin = '0;
      assign zin = in_z;
      assign tin = in_tag;
    end else begin : g_next
      assign xin = xs[i-1];
      assign yin = ys[i-1];
      assign zin = zs[i-1];
      assign tin = tg[i-1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        tg[i] <= '0;
      end else begin
        tg[i] <= tin;
      end
    end
    always_ff @(posedge clk) begin
      if (!zin[ZW-1]) begin
        xs[i] <= xin - (yin >>> i);
        ys[i] <= yin + (xin >>> i);
        zs[i] <= zin - ATAN_I;
      end else begin
        xs[i] <= xin + (yin >>> i);
        ys[i] <= yin - (xin >>> i);
        zs[i] <= zin + ATAN_I;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= tg[STAGES-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    unique case (tg[STAGES-1].quad)
      QUAD_0: begin
        sin_q <= ys[STAGES-1];
        cos_q <= xs[STAGES-1];
      end
      QUAD_1: begin
        sin_q <= xs[STAGES-1];
        cos_q <= -ys[STAGES-1];
      end
      QUAD_2: begin
        sin_q <= -ys[STAGES-1];
        cos_q <= -xs[STAGES-1];
      end
      default: begin
        sin_q <= -xs[STAGES-1];
        cos_q <= ys[STAGES-1];
      end
    endcase
  end

endmodule

// ===== sv/gcd_isqrt.sv =====
// Pipelined floor square root of a Q60 value, one result bit per stage.
module gcd_isqrt
  import gcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [60:0] v,
  output logic        valid,
  output logic [30:0] root
);

  localparam int NB = 31;
  localparam int SW = 62;

  logic [SW-1:0] rem [NB];
  logic [NB-1:0] rt  [NB];
  logic [NB-1:0] vl;

  for (genvar j = 0; j < NB; j++) begin : g_bit
    localparam int K = NB - 1 - j;
    logic [SW-1:0] rin, trial;
    logic [NB-1:0] tin;
    logic          vin;
    if (j == 0) begin : g_first
      assign rin = SW'(v);
      assign tin = '0;
      assign vin = in_valid;
    end else begin : g_next
      assign rin = rem[j-1];
      assign tin = rt[j-1];
      assign vin = vl[j-1];
    end
    assign trial = (SW'(tin) << (K + 1)) + (SW'(1) << (2 * K));
    always_ff @(posedge clk) begin
      if (rst) begin
        vl[j] <= 1'b0;
      end else begin
        vl[j] <= vin;
      end
    end
    always_ff @(posedge clk) begin
      if (rin >= trial) begin
        rem[j] <= rin - trial;
        rt[j]  <= tin | (NB'(1) << K);
      end else begin
        rem[j] <= rin;
        rt[j]  <= tin;
      end
    end
  end

  assign valid = vl[NB-1];
  assign root  = rt[NB-1];

endmodule

// ===== sv/gcd_cordic_vec.sv =====
// Vectoring-mode CORDIC pipeline giving atan2 of two nonnegative Q30 values.
module gcd_cordic_vec
  import gcd_pkg::*;
#(
  parameter int STAGES = CORDIC_STAGES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [30:0]          in_y,
  input  logic [30:0]          in_x,
  output logic                 valid,
  output logic signed [ZW-1:0] angle
);

  logic signed [XW-1:0] xs [STAGES];
  logic signed [XW-1:0] ys [STAGES];
  logic signed [ZW-1:0] zs [STAGES];
  logic [STAGES-1:0]    vl;

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [ZW-1:0] ATAN_I = atan_q30(i);
    logic signed [XW-1:0] xin, yin;
    logic signed [ZW-1:0] zin;
    logic                 vin;
    if (i == 0) begin : g_first
      assign xin = signed'(XW'(in_x));
      assign yin = signed'(XW'(in_y));
      assign zin = '0;
      assign vin = in_valid;
    end else begin : g_next
      assign xin = xs[i-1];
      assign yin = ys[i-1];
      assign zin = zs[i-1];
      assign vin = vl[i-1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vl[i] <= 1'b0;
      end else begin
        vl[i] <= vin;
      end
    end
    always_ff @(posedge clk) begin
      if (!yin[XW-1]) begin
        xs[i] <= xin + (yin >>> i);
        ys[i] <= yin - (xin >>> i);
        zs[i] <= zin + ATAN_I;
      end else begin
        xs[i] <= xin - (yin >>> i);
        ys[i] <= yin + (xin >>> i);
        zs[i] <= zin - ATAN_I;
      end
    end
  end

  assign valid = vl[STAGES-1];
  assign angle = zs[STAGES-1];

endmodule
